@@ rtl/ptc_pkg.sv @@
// Shared types, constants and arithmetic helpers for pressure/temperature compensation.
`default_nettype none
package ptc_pkg;

  localparam int unsigned NumRegs = 4;
  localparam int unsigned RegW    = 48;

  typedef enum logic [1:0] {
    REG_TEMP    = 2'd0,
    REG_PRESS_A = 2'd1,
    REG_PRESS_B = 2'd2,
    REG_PRESS_C = 2'd3
  } reg_idx_t;

  localparam logic [31:0] PressOffset = 32'd64000;
  localparam logic [31:0] PressBase   = 32'd1048576;
  localparam logic [31:0] PressScale  = 32'd3125;
  localparam logic [31:0] P1Bias      = 32'd32768;
  localparam logic [31:0] TempRound   = 32'd128;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } request_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic signed [31:0] fine_temperature;
    logic [31:0]        pressure_pa;
    logic               pressure_valid;
  } result_t;

  // Coefficients, already widened to 32-bit words.
  typedef struct packed {
    logic [31:0] t1, t2, t3;
    logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } coef_t;

  // Values that ride alongside the divider.
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] fine;
    logic        valid;
    logic        dbl;
  } side_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;
  } div_step_t;

  function automatic logic [31:0] sra(input logic [31:0] x, input logic [4:0] s);
    sra = 32'($signed(x) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] zx16(input logic [15:0] v);
    zx16 = {16'd0, v};
  endfunction

  // One restoring-division step: bring down the top dividend bit, shift in the quotient bit.
  function automatic div_step_t div_step(input logic [31:0] rem, input logic [31:0] num,
                                         input logic [31:0] den);
    logic [32:0] t;
    div_step_t   r;
    t = {rem, num[31]};
    if (t >= {1'b0, den}) begin
      r.rem = 32'(t - {1'b0, den});
      r.num = {num[30:0], 1'b1};
    end else begin
      r.rem = t[31:0];
      r.num = {num[30:0], 1'b0};
    end
    div_step = r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/pressure_temperature_compensation.sv @@
// Top level of the pressure/temperature compensation pipeline.
`default_nettype none
// Pipeline: a request is taken on every cycle that start is high
// (busy never rises), and its result appears with a one-cycle done strobe
// after 45 register stages in all. The depth is set by the 32-stage
// divider, which produces one quotient bit per stage, plus nine stages of
// multiply/shift work ahead of it and four after it.
// Results cannot be held off; capture them when done is high.
// Write the calibration registers only while no request is in flight.
module pressure_temperature_compensation (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire ptc_pkg::request_t request,
  output logic                   done,
  output ptc_pkg::result_t       result,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [47:0]       cfg_data
);
  import ptc_pkg::*;

  logic [RegW-1:0] temp_coeffs, press_coeffs_a, press_coeffs_b, press_coeffs_c;
  coef_t           coef;
  logic            f_valid, d_valid;
  logic [31:0]     num, den, quot;
  side_t           f_side, d_side;

  assign busy = 1'b0;

  // Calibration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs    <= '0;
      press_coeffs_a <= '0;
      press_coeffs_b <= '0;
      press_coeffs_c <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TEMP:    temp_coeffs    <= cfg_data;
        REG_PRESS_A: press_coeffs_a <= cfg_data;
        REG_PRESS_B: press_coeffs_b <= cfg_data;
        REG_PRESS_C: press_coeffs_c <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack and widen the coefficients
  always_comb begin
    coef.t1 = zx16(temp_coeffs[15:0]);
    coef.t2 = sx16(temp_coeffs[31:16]);
    coef.t3 = sx16(temp_coeffs[47:32]);
    coef.p1 = zx16(press_coeffs_a[15:0]);
    coef.p2 = sx16(press_coeffs_a[31:16]);
    coef.p3 = sx16(press_coeffs_a[47:32]);
    coef.p4 = sx16(press_coeffs_b[15:0]);
    coef.p5 = sx16(press_coeffs_b[31:16]);
    coef.p6 = sx16(press_coeffs_b[47:32]);
    coef.p7 = sx16(press_coeffs_c[15:0]);
    coef.p8 = sx16(press_coeffs_c[31:16]);
    coef.p9 = sx16(press_coeffs_c[47:32]);
  end

  ptc_front u_front (
    .clk, .rst,
    .in_valid (start & ~busy),
    .req      (request),
    .coef,
    .out_valid(f_valid),
    .num, .den,
    .side     (f_side)
  );

  ptc_div u_div (
    .clk, .rst,
    .in_valid (f_valid),
    .num, .den,
    .side_in  (f_side),
    .out_valid(d_valid),
    .quot,
    .side_out (d_side)
  );

  ptc_back u_back (
    .clk, .rst,
    .in_valid(d_valid),
    .quot,
    .side    (d_side),
    .coef,
    .done,
    .result
  );

endmodule
`default_nettype wire

@@ rtl/ptc_front.sv @@
// Temperature compensation and pressure pre-division stages.
`default_nettype none
module ptc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire ptc_pkg::request_t req,
  input  wire ptc_pkg::coef_t  coef,
  output logic                 out_valid,
  output logic [31:0]          num,
  output logic [31:0]          den,
  output ptc_pkg::side_t       side
);
  import ptc_pkg::*;

  logic [8:1] v;
  logic [31:0] m1, dd, adcp1, adcp2, adcp3, adcp4, adcp5, adcp6, adcp7;
  logic [31:0] a2, x2, fine3;
  logic [31:0] fine4, temp4, pa4, qq4;
  logic [31:0] fine5, temp5, b6m, a5m, p3m, p2m;
  logic [31:0] fine6, temp6, b6, a6;
  logic [31:0] fine7, temp7, b7, am7;
  logic [31:0] fine8, temp8, dv8, pn8;
  logic        val8;
  logic [31:0] adct, q3;

  assign adct = {12'd0, req.raw_temperature};
  assign q3   = sra(sra(fine3, 5'd1) - PressOffset, 5'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else begin
      v <= {v[7:1], in_valid};
      out_valid <= v[8];
    end
  end

  always_ff @(posedge clk) begin
    // Raw temperature products
    m1    <= 32'(((adct >> 3) - (coef.t1 << 1)) * coef.t2);
    dd    <= 32'(((adct >> 4) - coef.t1) * ((adct >> 4) - coef.t1));
    adcp1 <= {12'd0, req.raw_pressure};
    // Second temperature product
    a2    <= sra(m1, 5'd11);
    x2    <= 32'(sra(dd, 5'd12) * coef.t3);
    adcp2 <= adcp1;
    // Fine temperature
    fine3 <= a2 + sra(x2, 5'd14);
    adcp3 <= adcp2;
    // Centidegrees and pressure square term
    fine4 <= fine3;
    temp4 <= sra((fine3 << 2) + fine3 + TempRound, 5'd8);
    pa4   <= sra(fine3, 5'd1) - PressOffset;
    qq4   <= 32'(q3 * q3);
    adcp4 <= adcp3;
    // Coefficient products
    fine5 <= fine4;
    temp5 <= temp4;
    b6m   <= 32'(sra(qq4, 5'd11) * coef.p6);
    a5m   <= 32'(pa4 * coef.p5);
    p3m   <= 32'(coef.p3 * sra(qq4, 5'd13));
    p2m   <= 32'(coef.p2 * pa4);
    adcp5 <= adcp4;
    // Combine
    fine6 <= fine5;
    temp6 <= temp5;
    b6    <= sra(b6m + (a5m << 1), 5'd2) + (coef.p4 << 16);
    a6    <= sra(sra(p3m, 5'd3) + sra(p2m, 5'd1), 5'd18);
    adcp6 <= adcp5;
    // Divisor product
    fine7 <= fine6;
    temp7 <= temp6;
    b7    <= b6;
    am7   <= 32'((P1Bias + a6) * coef.p1);
    adcp7 <= adcp6;
    // Divisor and scaled numerator
    fine8 <= fine7;
    temp8 <= temp7;
    dv8   <= sra(am7, 5'd15);
    val8  <= (sra(am7, 5'd15) != 32'd0);
    pn8   <= 32'(((PressBase - adcp7) - sra(b7, 5'd12)) * PressScale);
    // Align dividend
    num        <= pn8[31] ? pn8 : (pn8 << 1);
    den        <= dv8;
    side.temp  <= temp8;
    side.fine  <= fine8;
    side.valid <= val8;
    side.dbl   <= pn8[31];
  end

endmodule
`default_nettype wire

@@ rtl/ptc_div.sv @@
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
`default_nettype none
module ptc_div (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic [31:0]    num,
  input  wire logic [31:0]    den,
  input  wire ptc_pkg::side_t side_in,
  output logic                out_valid,
  output logic [31:0]         quot,
  output ptc_pkg::side_t      side_out
);
  import ptc_pkg::*;

  localparam int unsigned Steps = 32;

  logic [Steps:1]  v;
  logic [31:0]     rem_r [1:Steps-1];
  logic [31:0]     num_r [1:Steps];
  logic [31:0]     den_r [1:Steps-1];
  side_t           side_r[1:Steps];
  div_step_t       step  [Steps];

  // The first step works straight on the incoming operands.
  always_comb begin
    step[0] = div_step('0, num, den);
    for (int k = 1; k < Steps; k++) begin
      step[k] = div_step(rem_r[k], num_r[k], den_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[Steps-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[1]  <= step[0].rem;
    num_r[1]  <= step[0].num;
    den_r[1]  <= den;
    side_r[1] <= side_in;
    for (int k = 1; k < Steps-1; k++) begin
      rem_r[k+1] <= step[k].rem;
      den_r[k+1] <= den_r[k];
    end
    for (int k = 1; k < Steps; k++) begin
      num_r[k+1]  <= step[k].num;
      side_r[k+1] <= side_r[k];
    end
  end

  assign out_valid = v[Steps];
  assign quot      = num_r[Steps];
  assign side_out  = side_r[Steps];

endmodule
`default_nettype wire

@@ rtl/ptc_back.sv @@
// Post-division pressure correction and result register.
`default_nettype none
module ptc_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  input  wire logic [31:0]    quot,
  input  wire ptc_pkg::side_t side,
  input  wire ptc_pkg::coef_t coef,
  output logic                done,
  output ptc_pkg::result_t    result
);
  import ptc_pkg::*;

  logic [3:1]  v;
  side_t       s1, s2, s3;
  logic [31:0] p1, p2, p3, sq2, b82, m93, b83;
  logic [31:0] ps1;

  assign ps1 = p1 >> 3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      done <= 1'b0;
    end else begin
      v    <= {v[2:1], in_valid};
      done <= v[3];
    end
  end

  always_ff @(posedge clk) begin
    // Undo dividend alignment
    s1  <= side;
    p1  <= side.dbl ? (quot << 1) : quot;
    // Square and P8 terms
    s2  <= s1;
    p2  <= p1;
    sq2 <= 32'(ps1 * ps1) >> 13;
    b82 <= 32'((p1 >> 2) * coef.p8);
    // P9 term
    s3  <= s2;
    p3  <= p2;
    m93 <= 32'(coef.p9 * sq2);
    b83 <= b82;
    // Final sum; drop pressure when the divisor was zero
    result.temperature_centi <= s3.temp;
    result.fine_temperature  <= s3.fine;
    result.pressure_valid    <= s3.valid;
    result.pressure_pa       <= s3.valid ?
        p3 + sra(sra(m93, 5'd12) + sra(b83, 5'd13) + coef.p7, 5'd4) : 32'd0;
  end

endmodule
`default_nettype wire
